FILE: design/crd_pkg.sv
// Shared widths, register codes and reset values for the camera ray direction block.
package crd_pkg;

    localparam int unsigned WIDTH_DEF  = 800;
    localparam int unsigned HEIGHT_DEF = 600;

    localparam int unsigned PIX_W      = 10;
    localparam int unsigned GAIN_W     = 20;
    localparam int unsigned TRIG_W     = 16;
    localparam int unsigned DIR_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    // signed raster offset, wide enough for dimensions up to 4096
    localparam int unsigned OFS_W  = 14;
    localparam int unsigned ND_W   = OFS_W + GAIN_W + 1;
    localparam int unsigned P1_W   = ND_W + TRIG_W;
    localparam int unsigned YS_W   = P1_W + 1;
    localparam int unsigned R1_W   = 40;
    localparam int unsigned P2_W   = R1_W + TRIG_W;
    localparam int unsigned PS_W   = P2_W + 1;
    localparam int unsigned RND_W  = PS_W + 1;
    localparam int unsigned R2_W   = 45;
    localparam int unsigned MAG_W  = R2_W - 1;
    localparam int unsigned A_W    = 30;
    localparam int unsigned SH_W   = 4;
    localparam int unsigned SQ_W   = 2 * A_W;
    localparam int unsigned SUM_W  = SQ_W + 2;
    localparam int unsigned ROOT_W = SUM_W / 2;
    localparam int unsigned REM_W  = ROOT_W + 4;
    localparam int unsigned Q_W    = 15;
    localparam int unsigned NUM_W  = A_W + Q_W;
    localparam int unsigned FRAC_Q24 = 24;
    localparam int unsigned RND_SH   = 14;
    localparam int unsigned OUT_SH   = 14;

    localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

    localparam logic [GAIN_W-1:0] X_GAIN_RST    = GAIN_W'(16144);
    localparam logic [GAIN_W-1:0] Y_GAIN_RST    = GAIN_W'(16144);
    localparam logic [TRIG_W-1:0] COS_YAW_RST   = TRIG_W'(16384);
    localparam logic [TRIG_W-1:0] SIN_YAW_RST   = TRIG_W'(0);
    localparam logic [TRIG_W-1:0] COS_PITCH_RST = TRIG_W'(16384);
    localparam logic [TRIG_W-1:0] SIN_PITCH_RST = TRIG_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_GAIN    = 3'd0,
        REG_Y_GAIN    = 3'd1,
        REG_COS_YAW   = 3'd2,
        REG_SIN_YAW   = 3'd3,
        REG_COS_PITCH = 3'd4,
        REG_SIN_PITCH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][A_W-1:0]   mag;
    } t_vec;

endpackage

FILE: design/camera_ray_direction.sv
// Pinhole camera ray generator: pixel position to unit view direction.
// One pixel beat enters every clock unless the output beat is stalled; the depth is
// set by the 31-step square root stage chain and the 15-step quotient stage chain per
// component, behind nine stages of offset, yaw and pitch rotation, scaling and squaring.
// The whole pipe advances together: it holds only while the output beat waits for i_ready.
// Configuration registers are written through the cfg channel, which is always ready.
module camera_ray_direction #(
    parameter int unsigned WIDTH  = crd_pkg::WIDTH_DEF,
    parameter int unsigned HEIGHT = crd_pkg::HEIGHT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [crd_pkg::PIX_W-1:0]              i_pixel_col,
    input  logic [crd_pkg::PIX_W-1:0]              i_pixel_row,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [crd_pkg::DIR_W-1:0]       o_dir_x,
    output logic signed [crd_pkg::DIR_W-1:0]       o_dir_y,
    output logic signed [crd_pkg::DIR_W-1:0]       o_dir_z,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [crd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [crd_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int unsigned OFS_W  = crd_pkg::OFS_W;
    localparam int unsigned ND_W   = crd_pkg::ND_W;
    localparam int unsigned P1_W   = crd_pkg::P1_W;
    localparam int unsigned YS_W   = crd_pkg::YS_W;
    localparam int unsigned R1_W   = crd_pkg::R1_W;
    localparam int unsigned P2_W   = crd_pkg::P2_W;
    localparam int unsigned PS_W   = crd_pkg::PS_W;
    localparam int unsigned RND_W  = crd_pkg::RND_W;
    localparam int unsigned R2_W   = crd_pkg::R2_W;
    localparam int unsigned MAG_W  = crd_pkg::MAG_W;
    localparam int unsigned A_W    = crd_pkg::A_W;
    localparam int unsigned SH_W   = crd_pkg::SH_W;
    localparam int unsigned SQ_W   = crd_pkg::SQ_W;
    localparam int unsigned SUM_W  = crd_pkg::SUM_W;
    localparam int unsigned ROOT_W = crd_pkg::ROOT_W;
    localparam int unsigned REM_W  = crd_pkg::REM_W;
    localparam int unsigned Q_W    = crd_pkg::Q_W;
    localparam int unsigned NUM_W  = crd_pkg::NUM_W;
    localparam int unsigned DIR_W  = crd_pkg::DIR_W;
    localparam int unsigned TRIG_W = crd_pkg::TRIG_W;
    localparam int unsigned GAIN_W = crd_pkg::GAIN_W;
    localparam int unsigned PIX_W  = crd_pkg::PIX_W;

    localparam int unsigned SQ_N  = ROOT_W;
    localparam int unsigned N_STG = 9 + SQ_N + 1 + Q_W + 1;

    localparam logic signed [OFS_W-1:0] WIDTH_S  = OFS_W'(WIDTH);
    localparam logic signed [OFS_W-1:0] HEIGHT_S = OFS_W'(HEIGHT);

    function automatic logic signed [R2_W-1:0] f_rnd(input logic signed [RND_W-1:0] v);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] m;
        logic [R2_W-1:0]  mt;
        mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        m   = (mag + (RND_W'(1) << (crd_pkg::RND_SH - 1))) >> crd_pkg::RND_SH;
        mt  = m[R2_W-1:0];
        return v[RND_W-1] ? $signed(-mt) : $signed(mt);
    endfunction

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [R2_W-1:0] v);
        logic [R2_W-1:0] a;
        a = v[R2_W-1] ? R2_W'(-v) : R2_W'(v);
        return a[MAG_W-1:0];
    endfunction

    // config registers
    logic [GAIN_W-1:0]        r_x_gain, r_y_gain;
    logic signed [TRIG_W-1:0] r_cos_yaw, r_sin_yaw, r_cos_pitch, r_sin_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain    <= crd_pkg::X_GAIN_RST;
            r_y_gain    <= crd_pkg::Y_GAIN_RST;
            r_cos_yaw   <= crd_pkg::COS_YAW_RST;
            r_sin_yaw   <= crd_pkg::SIN_YAW_RST;
            r_cos_pitch <= crd_pkg::COS_PITCH_RST;
            r_sin_pitch <= crd_pkg::SIN_PITCH_RST;
        end else if (i_cfg_valid) begin
            unique case (crd_pkg::t_cfg_idx'(i_cfg_index))
                crd_pkg::REG_X_GAIN:    r_x_gain    <= i_cfg_data;
                crd_pkg::REG_Y_GAIN:    r_y_gain    <= i_cfg_data;
                crd_pkg::REG_COS_YAW:   r_cos_yaw   <= i_cfg_data[TRIG_W-1:0];
                crd_pkg::REG_SIN_YAW:   r_sin_yaw   <= i_cfg_data[TRIG_W-1:0];
                crd_pkg::REG_COS_PITCH: r_cos_pitch <= i_cfg_data[TRIG_W-1:0];
                crd_pkg::REG_SIN_PITCH: r_sin_pitch <= i_cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipe control
    logic             w_en;
    logic [N_STG-1:0] r_vld;

    assign w_en    = !r_vld[N_STG-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[N_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STG-2:0], i_valid};
        end
    end

    // front stages: offsets, yaw, pitch, magnitudes, scaling, squares
    logic signed [OFS_W-1:0] w_ox, w_oy;
    logic signed [ND_W-1:0]  r_nx, r_ny, r_ny1, r_ny2;
    logic signed [P1_W-1:0]  r_px_c, r_px_s, r_py_c, r_py_s;
    logic signed [R1_W-1:0]  r_rx, r_rz, r_rx3;
    logic signed [P2_W-1:0]  r_pz_c, r_pz_s;
    logic signed [R2_W-1:0]  w_ry, w_rz2;
    logic [2:0][MAG_W-1:0]   r_m4, r_m5;
    logic [2:0]              r_n4, r_n5, r_n6, r_n7;
    logic [MAG_W-1:0]        w_mx;
    logic [SH_W-1:0]         w_sh, r_sh;
    logic [2:0][A_W-1:0]     r_a6, r_a7;
    logic [2:0][SQ_W-1:0]    r_sq7;

    assign w_ox = $signed({{(OFS_W-PIX_W-1){1'b0}}, i_pixel_col, 1'b1}) - WIDTH_S;
    assign w_oy = HEIGHT_S - $signed({{(OFS_W-PIX_W-1){1'b0}}, i_pixel_row, 1'b1});

    assign w_ry  = f_rnd(RND_W'(PS_W'(r_py_c) - PS_W'(r_pz_s)));
    assign w_rz2 = f_rnd(RND_W'(PS_W'(r_py_s) + PS_W'(r_pz_c)));

    always_comb begin
        w_mx = r_m4[0];
        if (r_m4[1] > w_mx) w_mx = r_m4[1];
        if (r_m4[2] > w_mx) w_mx = r_m4[2];
        w_sh = '0;
        for (int i = A_W; i < MAG_W; i++) begin
            if (w_mx[i]) w_sh = SH_W'(i - A_W + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx   <= ND_W'(w_ox * $signed({1'b0, r_x_gain}));
            r_ny   <= ND_W'(w_oy * $signed({1'b0, r_y_gain}));

            r_px_c <= P1_W'(r_nx * r_cos_yaw);
            r_px_s <= P1_W'(r_nx * r_sin_yaw);
            r_ny1  <= r_ny;

            r_rx   <= R1_W'(f_rnd(RND_W'(YS_W'(r_px_c)
                        - (YS_W'(r_sin_yaw) <<< crd_pkg::FRAC_Q24))));
            r_rz   <= R1_W'(f_rnd(RND_W'(YS_W'(r_px_s)
                        + (YS_W'(r_cos_yaw) <<< crd_pkg::FRAC_Q24))));
            r_ny2  <= r_ny1;

            r_py_c <= P1_W'(r_ny2 * r_cos_pitch);
            r_py_s <= P1_W'(r_ny2 * r_sin_pitch);
            r_pz_c <= P2_W'(r_rz * r_cos_pitch);
            r_pz_s <= P2_W'(r_rz * r_sin_pitch);
            r_rx3  <= r_rx;

            r_m4[0] <= f_mag(R2_W'(r_rx3));
            r_m4[1] <= f_mag(w_ry);
            r_m4[2] <= f_mag(w_rz2);
            r_n4    <= {w_rz2[R2_W-1], w_ry[R2_W-1], r_rx3[R1_W-1]};

            r_m5 <= r_m4;
            r_n5 <= r_n4;
            r_sh <= w_sh;

            for (int l = 0; l < 3; l++) begin
                r_a6[l]  <= A_W'(r_m5[l] >> r_sh);
                r_sq7[l] <= SQ_W'(r_a6[l] * r_a6[l]);
            end
            r_n6 <= r_n5;
            r_a7 <= r_a6;
            r_n7 <= r_n6;
        end
    end

    // square root, one result bit per stage
    logic [SUM_W-1:0]  r_sv   [0:SQ_N];
    logic [REM_W-1:0]  r_rem  [0:SQ_N];
    logic [ROOT_W-1:0] r_root [0:SQ_N];
    crd_pkg::t_vec     r_sside[0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sv[0]            <= SUM_W'(r_sq7[0]) + SUM_W'(r_sq7[1]) + SUM_W'(r_sq7[2]);
            r_rem[0]           <= '0;
            r_root[0]          <= '0;
            r_sside[0].neg     <= r_n7;
            r_sside[0].mag     <= r_a7;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic [REM_W-1:0] w_rsh, w_trial;
        assign w_rsh   = {r_rem[k][REM_W-3:0], r_sv[k][SUM_W-1-2*k -: 2]};
        assign w_trial = REM_W'({r_root[k], 2'b01});
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sv[k+1]    <= r_sv[k];
                r_sside[k+1] <= r_sside[k];
                if (w_rsh >= w_trial) begin
                    r_rem[k+1]  <= w_rsh - w_trial;
                    r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= w_rsh;
                    r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // rounded division of each magnitude by the length, one quotient bit per stage
    logic [NUM_W-1:0]  r_drem [0:Q_W][0:2];
    logic [Q_W-1:0]    r_dq   [0:Q_W][0:2];
    logic [ROOT_W-1:0] r_dlen [0:Q_W];
    logic [2:0]        r_dneg [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_drem[0][l] <= (NUM_W'(r_sside[SQ_N].mag[l]) << crd_pkg::OUT_SH)
                                + NUM_W'(r_root[SQ_N] >> 1);
                r_dq[0][l]   <= '0;
            end
            r_dlen[0] <= r_root[SQ_N];
            r_dneg[0] <= r_sside[SQ_N].neg;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [NUM_W-1:0] w_d;
        assign w_d = NUM_W'(r_dlen[j]) << (Q_W - 1 - j);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dlen[j+1] <= r_dlen[j];
                r_dneg[j+1] <= r_dneg[j];
                for (int l = 0; l < 3; l++) begin
                    if (r_drem[j][l] >= w_d) begin
                        r_drem[j+1][l] <= r_drem[j][l] - w_d;
                        r_dq[j+1][l]   <= r_dq[j][l] | (Q_W'(1) << (Q_W - 1 - j));
                    end else begin
                        r_drem[j+1][l] <= r_drem[j][l];
                        r_dq[j+1][l]   <= r_dq[j][l];
                    end
                end
            end
        end
    end

    // output: zero length, clamp, sign
    logic [2:0][DIR_W-1:0] r_dir;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                if (r_dlen[Q_W] == '0) begin
                    r_dir[l] <= '0;
                end else if (r_dq[Q_W][l] > crd_pkg::ONE_Q14) begin
                    r_dir[l] <= r_dneg[Q_W][l] ? DIR_W'(-DIR_W'(crd_pkg::ONE_Q14))
                                               : DIR_W'(crd_pkg::ONE_Q14);
                end else begin
                    r_dir[l] <= r_dneg[Q_W][l] ? DIR_W'(-DIR_W'(r_dq[Q_W][l]))
                                               : DIR_W'(r_dq[Q_W][l]);
                end
            end
        end
    end

    assign o_dir_x = $signed(r_dir[0]);
    assign o_dir_y = $signed(r_dir[1]);
    assign o_dir_z = $signed(r_dir[2]);

endmodule

FILE: design/crd_chk.sv
// Port-level checker for the camera ray direction block, bound to the top level.
module crd_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic signed [crd_pkg::DIR_W-1:0]       o_dir_x,
    input logic signed [crd_pkg::DIR_W-1:0]       o_dir_y,
    input logic signed [crd_pkg::DIR_W-1:0]       o_dir_z
);

    localparam logic signed [crd_pkg::DIR_W-1:0] LIM_HI = crd_pkg::DIR_W'(16384);
    localparam logic signed [crd_pkg::DIR_W-1:0] LIM_LO = crd_pkg::DIR_W'(-16384);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat present after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dir_x) && $stable(o_dir_y)
                                && $stable(o_dir_z))
        else $error("stalled output beat changed");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready == (!o_valid || i_ready)))
        else $error("input ready does not follow output drain");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_dir_x <= LIM_HI && o_dir_x >= LIM_LO && o_dir_y <= LIM_HI
                    && o_dir_y >= LIM_LO && o_dir_z <= LIM_HI && o_dir_z >= LIM_LO)
        else $error("direction component beyond unit range");

endmodule

bind camera_ray_direction crd_chk u_crd_chk (.*);

FILE: test/tb.sv
// Self-checking testbench for camera_ray_direction: directed table, then random phases.
module tb;

    typedef struct {
        logic signed [crd_pkg::DIR_W-1:0] x;
        logic signed [crd_pkg::DIR_W-1:0] y;
        logic signed [crd_pkg::DIR_W-1:0] z;
    } t_dir;

    typedef enum logic [1:0] {ROW_PIX, ROW_FIX, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                        kind;
        logic [crd_pkg::CFG_IDX_W-1:0]    idx;
        logic [crd_pkg::CFG_DATA_W-1:0]   data;
        logic [crd_pkg::PIX_W-1:0]        col;
        logic [crd_pkg::PIX_W-1:0]        row;
        logic signed [crd_pkg::DIR_W-1:0] ex;
        logic signed [crd_pkg::DIR_W-1:0] ey;
        logic signed [crd_pkg::DIR_W-1:0] ez;
    } t_step;

    localparam int DRAIN_CYC = 70;
    localparam int WDOG_LIM  = 5000;
    localparam int HOLD_CYC  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [crd_pkg::PIX_W-1:0] i_pixel_col = '0;
    logic [crd_pkg::PIX_W-1:0] i_pixel_row = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [crd_pkg::DIR_W-1:0] o_dir_x, o_dir_y, o_dir_z;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [crd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [crd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    camera_ray_direction uut (.*);

    always #1 i_clk = ~i_clk;

    logic [crd_pkg::GAIN_W-1:0] m_xg, m_yg;
    logic [crd_pkg::TRIG_W-1:0] m_cy, m_sy, m_cp, m_sp;

    t_dir dir_q[$];
    int   n_err = 0;
    int   n_pix = 0;
    int   n_dir = 0;
    int   n_cfg = 0;
    int   rx_mode = 0;
    logic hold_req = 1'b0;
    int   idle_cyc = 0;

    function automatic longint q38_to_q24(longint v);
        longint unsigned m;
        m = ((v < 0) ? -v : v) + 64'd8192;
        m = m >> 14;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [crd_pkg::DIR_W-1:0] unit_comp(bit neg,
            longint unsigned m, longint unsigned len);
        longint unsigned q;
        if (len == 0) return '0;
        q = ((m << 14) + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        return neg ? -crd_pkg::DIR_W'(q) : crd_pkg::DIR_W'(q);
    endfunction

    function automatic t_dir ray_dir(logic [crd_pkg::PIX_W-1:0] col,
                                     logic [crd_pkg::PIX_W-1:0] row);
        longint nx, ny, nz, rx, rz, ry, rz2, cy, sy, cp, sp;
        longint unsigned ax, ay, az, mx, len;
        t_dir d;
        cy = longint'($signed(m_cy));
        sy = longint'($signed(m_sy));
        cp = longint'($signed(m_cp));
        sp = longint'($signed(m_sp));
        nx = (2 * longint'(col) + 1 - 800) * longint'(m_xg);
        ny = (600 - 2 * longint'(row) - 1) * longint'(m_yg);
        nz = 64'd1 << 24;
        rx = q38_to_q24(nx * cy - nz * sy);
        rz = q38_to_q24(nx * sy + nz * cy);
        ry = q38_to_q24(ny * cp - rz * sp);
        rz2 = q38_to_q24(ny * sp + rz * cp);
        ax = (rx < 0) ? -rx : rx;
        ay = (ry < 0) ? -ry : ry;
        az = (rz2 < 0) ? -rz2 : rz2;
        mx = ax;
        if (ay > mx) mx = ay;
        if (az > mx) mx = az;
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            ax = ax >> 1;
            ay = ay >> 1;
            az = az >> 1;
        end
        len = int_sqrt(ax * ax + ay * ay + az * az);
        d.x = unit_comp(rx < 0, ax, len);
        d.y = unit_comp(ry < 0, ay, len);
        d.z = unit_comp(rz2 < 0, az, len);
        return d;
    endfunction

    task automatic report_err(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_dir);
        n_err++;
    endtask

    task automatic reg_write(logic [crd_pkg::CFG_IDX_W-1:0] idx,
                             logic [crd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            crd_pkg::REG_X_GAIN:    m_xg = data[crd_pkg::GAIN_W-1:0];
            crd_pkg::REG_Y_GAIN:    m_yg = data[crd_pkg::GAIN_W-1:0];
            crd_pkg::REG_COS_YAW:   m_cy = data[crd_pkg::TRIG_W-1:0];
            crd_pkg::REG_SIN_YAW:   m_sy = data[crd_pkg::TRIG_W-1:0];
            crd_pkg::REG_COS_PITCH: m_cp = data[crd_pkg::TRIG_W-1:0];
            crd_pkg::REG_SIN_PITCH: m_sp = data[crd_pkg::TRIG_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // leaves valid high; caller drops it for a gap
    task automatic send_pixel(logic [crd_pkg::PIX_W-1:0] col, logic [crd_pkg::PIX_W-1:0] row,
                              bit typed, t_dir want);
        i_pixel_col = col;
        i_pixel_row = row;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        dir_q.push_back(typed ? want : ray_dir(col, row));
        n_pix++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (dir_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    function automatic logic [crd_pkg::CFG_DATA_W-1:0] rand_trig();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return crd_pkg::CFG_DATA_W'($urandom);
        if (r == 1) return crd_pkg::CFG_DATA_W'(16384);
        if (r == 2) return crd_pkg::CFG_DATA_W'(-16384);
        return crd_pkg::CFG_DATA_W'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [crd_pkg::CFG_DATA_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return crd_pkg::CFG_DATA_W'($urandom);
        if (r == 1) return '1;
        if (r == 2) return '0;
        return crd_pkg::CFG_DATA_W'($urandom_range(0, 60000));
    endfunction

    // output check
    always @(posedge i_clk) begin
        t_dir w;
        if (i_rst_n && o_valid && i_ready) begin
            if (dir_q.size() == 0) begin
                $display("unexpected direction beat");
                n_err++;
            end else begin
                w = dir_q.pop_front();
                if (o_dir_x !== w.x) report_err("dir_x", o_dir_x, w.x);
                if (o_dir_y !== w.y) report_err("dir_y", o_dir_y, w.y);
                if (o_dir_z !== w.z) report_err("dir_z", o_dir_z, w.z);
            end
            n_dir++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_LIM) begin
            $display("timeout, %0d results still pending", dir_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver
    initial begin
        int ph;
        ph = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
            end
            ph++;
            case (rx_mode)
                0: i_ready = 1'b1;
                1: i_ready = ($urandom_range(0, 1) == 1);
                2: i_ready = (ph % 5) != 0;
                default: i_ready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    t_step steps[] = '{
        '{ROW_PIX, 0, 0, 400, 300, 0, 0, 0},
        '{ROW_PIX, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_PIX, 0, 0, 799, 599, 0, 0, 0},
        '{ROW_PIX, 0, 0, 1023, 1023, 0, 0, 0},
        '{ROW_PIX, 0, 0, 1023, 0, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_X_GAIN, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_Y_GAIN, 0, 0, 0, 0, 0, 0},
        '{ROW_FIX, 0, 0, 0, 0, 0, 0, 16384},
        '{ROW_FIX, 0, 0, 1023, 1023, 0, 0, 16384},
        '{ROW_CFG, crd_pkg::REG_COS_YAW, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_SIN_YAW, 16384, 0, 0, 0, 0, 0},
        '{ROW_FIX, 0, 0, 5, 5, -16384, 0, 0},
        '{ROW_CFG, crd_pkg::REG_SIN_YAW, 0, 0, 0, 0, 0, 0},
        '{ROW_FIX, 0, 0, 300, 200, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_COS_YAW, 20'hFC000, 0, 0, 0, 0, 0},
        '{ROW_FIX, 0, 0, 799, 0, 0, 0, -16384},
        '{ROW_CFG, 3'd6, 20'h12345, 0, 0, 0, 0, 0},
        '{ROW_CFG, 3'd7, 20'hFFFFF, 0, 0, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_X_GAIN, 20'hFFFFF, 0, 0, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_Y_GAIN, 20'hFFFFF, 0, 0, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_COS_PITCH, 20'h07FFF, 0, 0, 0, 0, 0},
        '{ROW_CFG, crd_pkg::REG_SIN_PITCH, 20'h08000, 0, 0, 0, 0, 0},
        '{ROW_PIX, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_PIX, 0, 0, 799, 599, 0, 0, 0},
        '{ROW_PIX, 0, 0, 1023, 1023, 0, 0, 0}
    };

    initial begin
        t_dir w;
        int burst, phase, k;
        logic [crd_pkg::PIX_W-1:0] c, r;
        m_xg = crd_pkg::X_GAIN_RST;
        m_yg = crd_pkg::Y_GAIN_RST;
        m_cy = crd_pkg::COS_YAW_RST;
        m_sy = crd_pkg::SIN_YAW_RST;
        m_cp = crd_pkg::COS_PITCH_RST;
        m_sp = crd_pkg::SIN_PITCH_RST;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (steps[i]) begin
            if (steps[i].kind == ROW_CFG) begin
                wait_drained();
                reg_write(steps[i].idx, steps[i].data);
            end else begin
                w.x = steps[i].ex;
                w.y = steps[i].ey;
                w.z = steps[i].ez;
                send_pixel(steps[i].col, steps[i].row, steps[i].kind == ROW_FIX, w);
            end
        end
        wait_drained();

        for (phase = 0; phase < 7; phase++) begin
            rx_mode = phase % 4;
            reg_write(crd_pkg::REG_X_GAIN, rand_gain());
            reg_write(crd_pkg::REG_Y_GAIN, rand_gain());
            reg_write(crd_pkg::REG_COS_YAW, rand_trig());
            reg_write(crd_pkg::REG_SIN_YAW, rand_trig());
            reg_write(crd_pkg::REG_COS_PITCH, rand_trig());
            reg_write(crd_pkg::REG_SIN_PITCH, rand_trig());
            if ($urandom_range(0, 2) == 0)
                reg_write(crd_pkg::CFG_IDX_W'($urandom_range(6, 7)),
                          crd_pkg::CFG_DATA_W'($urandom));
            if (phase == 2) hold_req = 1'b1;
            burst = $urandom_range(1, 30);
            for (k = 0; k < 100; k++) begin
                if (burst == 0) begin
                    i_valid = 1'b0;
                    repeat ($urandom_range(1, 8)) @(negedge i_clk);
                    burst = $urandom_range(1, 30);
                end
                burst--;
                if ($urandom_range(0, 9) == 0) begin
                    c = crd_pkg::PIX_W'($urandom);
                    r = crd_pkg::PIX_W'($urandom);
                end else begin
                    c = crd_pkg::PIX_W'($urandom_range(0, 799));
                    r = crd_pkg::PIX_W'($urandom_range(0, 599));
                end
                send_pixel(c, r, 1'b0, w);
            end
            wait_drained();
        end

        $display("%0d pixels, %0d directions, %0d register writes over 7 random settings",
                 n_pix, n_dir, n_cfg);
        $display("covered gain and angle extremes, out-of-range pixels and zero-length rays");
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
